// File: src/rlpm_pkg.sv
// Package for the IPv4 longest-prefix route table.
// Holds sizes, codes, word types and the result-word helper; no dependencies.
`timescale 1ns / 1ps
package rlpm_pkg;
   localparam int ROUTE_SLOTS = 64;
   localparam int INTERFACE_COUNT = 16;
   localparam int SLOT_BITS = $clog2(ROUTE_SLOTS);
   localparam int COUNT_BITS = $clog2(ROUTE_SLOTS + 1);

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_UNICAST = 2'd2,
      KIND_MULTICAST = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK = 3'd0,
      STATUS_BAD_DEFAULT = 3'd1,
      STATUS_NO_IFACE = 3'd2,
      STATUS_FULL = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [31:0] host;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [4:0] itf;
      logic is_multicast;
   } route_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [31:0] address;
      logic [31:0] netmask;
      logic [31:0] gateway;
      logic [4:0] interface_id;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic found;
      logic [31:0] next_hop;
      logic [4:0] out_interface;
      logic last;
   } rsp_word_type;

   function automatic rsp_word_type make_rsp(input status_type st, input logic fnd,
         input logic [31:0] hop, input logic [4:0] itf, input logic lst);
      rsp_word_type w;
      w.status = st;
      w.found = fnd;
      w.next_hop = hop;
      w.out_interface = itf;
      w.last = lst;
      return w;
   endfunction
endpackage

// File: src/rlpm_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on nothing.
`timescale 1ns / 1ps
interface rlpm_req_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [31:0] address;
   logic [31:0] netmask;
   logic [31:0] gateway;
   logic [4:0] interface_id;
   modport source (output valid, kind, address, netmask, gateway, interface_id,
      input ready);
   modport sink (input valid, kind, address, netmask, gateway, interface_id,
      output ready);
endinterface

interface rlpm_rsp_if;
   logic valid;
   logic ready;
   logic [2:0] status;
   logic found;
   logic [31:0] next_hop;
   logic [4:0] out_interface;
   logic last;
   modport source (output valid, status, found, next_hop, out_interface, last,
      input ready);
   modport sink (input valid, status, found, next_hop, out_interface, last,
      output ready);
endinterface

// File: src/rlpm_ram.sv
// Generic one-write, one-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module rlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input logic clock,
   input logic we,
   input logic [ADDR_BITS-1:0] waddr,
   input logic [WIDTH-1:0] wdata,
   input logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: src/ipv4_longest_prefix_route_table.sv
// IPv4 route table: add, delete with compaction, longest-prefix and multicast lookup.
// Add: result registered in the cycle after acceptance. Delete and lookups: scan the
// stored routes one by one from the RAM read port; multicast may load its final word
// from a flush state. One item at a time: ready again once the final word is loaded and
// the output is free; an output stall holds the scan only where it must load a word.
// Synchronous active-high reset empties the table; no clearing pass.
`timescale 1ns / 1ps
module ipv4_longest_prefix_route_table
   import rlpm_pkg::*;
(
   input logic clock,
   input logic reset,
   rlpm_req_if.sink req,
   rlpm_rsp_if.source rsp
);
   state_type state_ff, state_in;
   req_word_type cmd_ff, cmd_in;
   logic [COUNT_BITS-1:0] ptr_ff, ptr_in, count_ff, count_in;
   logic have_ff, have_in;
   logic [31:0] best_mask_ff, best_mask_in, best_gw_ff, best_gw_in;
   logic [4:0] best_itf_ff, best_itf_in;
   rsp_word_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic we;
   logic [SLOT_BITS-1:0] waddr, raddr;
   route_type wdata, e;
   logic [$bits(route_type)-1:0] rdata;
   logic load, free, last_entry, hit, fmatch, better, mhit;
   rsp_word_type load_word;
   logic [COUNT_BITS-1:0] ptr_next;

   rlpm_ram #(.WIDTH($bits(route_type)), .DEPTH(ROUTE_SLOTS)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata),
      .raddr(raddr), .rdata(rdata)
   );

   assign e = route_type'(rdata);
   assign free = !rsp_valid_ff || rsp.ready;
   assign ptr_next = ptr_ff + 1'b1;
   assign last_entry = (ptr_next == count_ff);
   assign hit = ((cmd_ff.address ^ e.host) & e.mask) == 32'd0;
   assign fmatch = (e.host == cmd_ff.address) && (e.mask == cmd_ff.netmask) &&
      (e.gateway == cmd_ff.gateway) && (e.itf == cmd_ff.interface_id);
   assign better = !e.is_multicast && hit && (!have_ff || e.mask > best_mask_ff);
   assign mhit = e.is_multicast && hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      ptr_ff <= ptr_in;
      have_ff <= have_in;
      best_mask_ff <= best_mask_in;
      best_gw_ff <= best_gw_in;
      best_itf_ff <= best_itf_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      ptr_in = ptr_ff;
      count_in = count_ff;
      have_in = have_ff;
      best_mask_in = best_mask_ff;
      best_gw_in = best_gw_ff;
      best_itf_in = best_itf_ff;
      raddr = ptr_ff[SLOT_BITS-1:0];
      we = 1'b0;
      waddr = count_ff[SLOT_BITS-1:0];
      wdata.host = req.address;
      wdata.mask = req.netmask;
      wdata.gateway = req.gateway;
      wdata.itf = req.interface_id;
      wdata.is_multicast = (req.address[31:28] == 4'hE);
      load = 1'b0;
      load_word = make_rsp(STATUS_NOT_FOUND, 1'b0, 32'd0, 5'd0, 1'b1);
      req.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req.ready = free && !reset;
            raddr = '0;
            if (req.valid && free && !reset) begin
               cmd_in = {req.kind, req.address, req.netmask, req.gateway,
                  req.interface_id};
               ptr_in = '0;
               have_in = 1'b0;
               if (kind_type'(req.kind) == KIND_ADD) begin
                  load = 1'b1;
                  if ((req.address == 32'd0) != (req.netmask == 32'd0)) begin
                     load_word = make_rsp(STATUS_BAD_DEFAULT, 1'b0, 32'd0, 5'd0, 1'b1);
                  end else if (req.interface_id == 5'd0 ||
                        {3'b000, req.interface_id} > 8'(INTERFACE_COUNT)) begin
                     load_word = make_rsp(STATUS_NO_IFACE, 1'b0, 32'd0, 5'd0, 1'b1);
                  end else if (count_ff == COUNT_BITS'(ROUTE_SLOTS)) begin
                     load_word = make_rsp(STATUS_FULL, 1'b0, 32'd0, 5'd0, 1'b1);
                  end else begin
                     load_word = make_rsp(STATUS_OK, 1'b0, 32'd0, 5'd0, 1'b1);
                     we = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else if (count_ff == '0) begin
                  load = 1'b1;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            case (kind_type'(cmd_ff.kind))
               KIND_DELETE: begin
                  if (fmatch && last_entry) begin
                     if (free) begin
                        load = 1'b1;
                        load_word = make_rsp(STATUS_OK, 1'b0, 32'd0, 5'd0, 1'b1);
                        count_in = count_ff - 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else if (fmatch) begin
                     ptr_in = ptr_next;
                     raddr = ptr_next[SLOT_BITS-1:0];
                     state_in = ST_SHIFT;
                  end else if (last_entry) begin
                     if (free) begin
                        load = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     ptr_in = ptr_next;
                     raddr = ptr_next[SLOT_BITS-1:0];
                  end
               end
               KIND_UNICAST: begin
                  if (last_entry) begin
                     if (free) begin
                        load = 1'b1;
                        state_in = ST_IDLE;
                        if (better) begin
                           load_word = make_rsp(STATUS_OK, 1'b1, e.gateway, e.itf, 1'b1);
                        end else if (have_ff) begin
                           load_word = make_rsp(STATUS_OK, 1'b1, best_gw_ff, best_itf_ff,
                              1'b1);
                        end
                     end
                  end else begin
                     ptr_in = ptr_next;
                     raddr = ptr_next[SLOT_BITS-1:0];
                     if (better) begin
                        have_in = 1'b1;
                        best_mask_in = e.mask;
                        best_gw_in = e.gateway;
                        best_itf_in = e.itf;
                     end
                  end
               end
               default: begin
                  if (mhit && have_ff) begin
                     if (free) begin
                        load = 1'b1;
                        load_word = make_rsp(STATUS_OK, 1'b1, best_gw_ff, best_itf_ff, 1'b0);
                        best_gw_in = e.gateway;
                        best_itf_in = e.itf;
                        if (last_entry) begin
                           state_in = ST_FLUSH;
                        end else begin
                           ptr_in = ptr_next;
                           raddr = ptr_next[SLOT_BITS-1:0];
                        end
                     end
                  end else if (mhit && last_entry) begin
                     if (free) begin
                        load = 1'b1;
                        load_word = make_rsp(STATUS_OK, 1'b1, e.gateway, e.itf, 1'b1);
                        state_in = ST_IDLE;
                     end
                  end else if (mhit) begin
                     have_in = 1'b1;
                     best_gw_in = e.gateway;
                     best_itf_in = e.itf;
                     ptr_in = ptr_next;
                     raddr = ptr_next[SLOT_BITS-1:0];
                  end else if (last_entry) begin
                     if (free) begin
                        load = 1'b1;
                        state_in = ST_IDLE;
                        if (have_ff) begin
                           load_word = make_rsp(STATUS_OK, 1'b1, best_gw_ff, best_itf_ff,
                              1'b1);
                        end
                     end
                  end else begin
                     ptr_in = ptr_next;
                     raddr = ptr_next[SLOT_BITS-1:0];
                  end
               end
            endcase
         end
         ST_SHIFT: begin
            we = 1'b1;
            waddr = SLOT_BITS'(ptr_ff - 1'b1);
            wdata = e;
            if (last_entry) begin
               if (free) begin
                  load = 1'b1;
                  load_word = make_rsp(STATUS_OK, 1'b0, 32'd0, 5'd0, 1'b1);
                  count_in = count_ff - 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               ptr_in = ptr_next;
               raddr = ptr_next[SLOT_BITS-1:0];
            end
         end
         ST_FLUSH: begin
            if (free) begin
               load = 1'b1;
               load_word = make_rsp(STATUS_OK, 1'b1, best_gw_ff, best_itf_ff, 1'b1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in = load ? load_word : rsp_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = rsp_ff.status;
   assign rsp.found = rsp_ff.found;
   assign rsp.next_hop = rsp_ff.next_hop;
   assign rsp.out_interface = rsp_ff.out_interface;
   assign rsp.last = rsp_ff.last;
endmodule

// File: tb/ipv4_longest_prefix_route_table_tb.sv
// Testbench for the IPv4 longest-prefix route table: directed and random
// add/delete/lookup traffic checked against a behavioral route table.
// Depends on rlpm_pkg, rlpm_if and the ipv4_longest_prefix_route_table RTL.
`timescale 1ns / 1ps
module ipv4_longest_prefix_route_table_tb;
   import rlpm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   rlpm_req_if req ();
   rlpm_rsp_if rsp ();

   ipv4_longest_prefix_route_table i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   route_type routes[$];
   rsp_word_type pending_words[$];
   req_word_type send_q[$];
   int errors = 0;
   int words_checked = 0;
   int items_sent = 0;
   int items_queued = 0;
   int gap_left = 0;
   longint cycles = 0;
   bit hold_off = 1'b0;
   bit burst_mode = 1'b1;
   int hold_cycles = 0;

   function automatic void queue_word(input rsp_word_type w);
      pending_words.insert(pending_words.size(), w);
   endfunction

   function automatic void predict(input req_word_type w);
      route_type r;
      int best;
      int n;
      int del_idx;
      case (kind_type'(w.kind))
         KIND_ADD: begin
            if ((w.address == 0) != (w.netmask == 0))
               queue_word(make_rsp(STATUS_BAD_DEFAULT, 0, 0, 0, 1));
            else if (w.interface_id == 0 || w.interface_id > INTERFACE_COUNT)
               queue_word(make_rsp(STATUS_NO_IFACE, 0, 0, 0, 1));
            else if (routes.size() >= ROUTE_SLOTS)
               queue_word(make_rsp(STATUS_FULL, 0, 0, 0, 1));
            else begin
               r.host = w.address;
               r.mask = w.netmask;
               r.gateway = w.gateway;
               r.itf = w.interface_id;
               r.is_multicast = (w.address[31:28] == 4'hE);
               routes.insert(routes.size(), r);
               queue_word(make_rsp(STATUS_OK, 0, 0, 0, 1));
            end
         end
         KIND_DELETE: begin
            del_idx = -1;
            foreach (routes[i]) begin
               if (del_idx < 0 && routes[i].host == w.address && routes[i].mask == w.netmask
                     && routes[i].gateway == w.gateway && routes[i].itf == w.interface_id)
                  del_idx = i;
            end
            if (del_idx >= 0) routes.delete(del_idx);
            queue_word(make_rsp((del_idx >= 0) ? STATUS_OK : STATUS_NOT_FOUND,
               0, 0, 0, 1));
         end
         KIND_UNICAST: begin
            best = -1;
            foreach (routes[i])
               if (!routes[i].is_multicast && ((w.address ^ routes[i].host) & routes[i].mask) == 0)
                  if (best < 0 || routes[i].mask > routes[best].mask) best = i;
            if (best < 0)
               queue_word(make_rsp(STATUS_NOT_FOUND, 0, 0, 0, 1));
            else
               queue_word(make_rsp(STATUS_OK, 1, routes[best].gateway,
                  routes[best].itf, 1));
         end
         default: begin
            n = 0;
            foreach (routes[i])
               if (routes[i].is_multicast && ((w.address ^ routes[i].host) & routes[i].mask) == 0) begin
                  queue_word(make_rsp(STATUS_OK, 1, routes[i].gateway,
                     routes[i].itf, 0));
                  n++;
               end
            if (n == 0)
               queue_word(make_rsp(STATUS_NOT_FOUND, 0, 0, 0, 1));
            else
               pending_words[pending_words.size() - 1].last = 1'b1;
         end
      endcase
   endfunction

   initial begin
      req.valid = 1'b0;
      req.kind = '0;
      req.address = '0;
      req.netmask = '0;
      req.gateway = '0;
      req.interface_id = '0;
      rsp.ready = 1'b0;
   end

   // offer the head word; hold it until accepted, idle during gaps
   always @(negedge clock) begin
      if (reset || send_q.size() == 0 || gap_left > 0) begin
         req.valid <= 1'b0;
         if (gap_left > 0) gap_left = gap_left - 1;
      end else begin
         req.valid <= 1'b1;
         req.kind <= send_q[0].kind;
         req.address <= send_q[0].address;
         req.netmask <= send_q[0].netmask;
         req.gateway <= send_q[0].gateway;
         req.interface_id <= send_q[0].interface_id;
      end
   end

   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         predict(send_q.pop_front());
         items_sent++;
         if (!burst_mode || $urandom_range(0, 3) == 0)
            gap_left = $urandom_range(1, burst_mode ? 6 : 1);
      end
   end

   task automatic send_word(input kind_type k, input logic [31:0] a, input logic [31:0] m,
         input logic [31:0] g, input logic [4:0] itf);
      req_word_type w;
      int ticket;
      w.kind = k;
      w.address = a;
      w.netmask = m;
      w.gateway = g;
      w.interface_id = itf;
      send_q.insert(send_q.size(), w);
      items_queued++;
      ticket = items_queued;
      wait (items_sent >= ticket);
   endtask

   // receiver stall pattern, overridden by a long hold-off
   always @(negedge clock) begin
      if (reset || hold_off) rsp.ready <= 1'b0;
      else rsp.ready <= ((cycles % 23) < 15) || ($urandom_range(0, 1) == 1);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      if (cycles > 400000) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_words.size() == 0) begin
            $display("%0t unexpected word: st=%0d found=%0b hop=%h itf=%0d last=%0b", $time,
               rsp.status, rsp.found, rsp.next_hop, rsp.out_interface, rsp.last);
            errors++;
         end else begin
            exp_w = pending_words.pop_front();
            words_checked++;
            if (rsp.status !== exp_w.status || rsp.found !== exp_w.found
                  || rsp.next_hop !== exp_w.next_hop || rsp.out_interface !== exp_w.out_interface
                  || rsp.last !== exp_w.last) begin
               $display("%0t mismatch: expected st=%0d found=%0b hop=%h itf=%0d last=%0b",
                  $time, exp_w.status, exp_w.found, exp_w.next_hop, exp_w.out_interface,
                  exp_w.last);
               $display("%0t            actual st=%0d found=%0b hop=%h itf=%0d last=%0b",
                  $time, rsp.status, rsp.found, rsp.next_hop, rsp.out_interface, rsp.last);
               errors++;
            end
         end
      end
   end

   function automatic logic [31:0] prefix_mask(input int len);
      return (len == 0) ? 32'h0 : ~32'h0 << (32 - len);
   endfunction

   task automatic drain();
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   task automatic test_add_checks();
      send_word(KIND_ADD, 32'h0, 32'hFFFF_0000, 32'h1, 5'd1);
      send_word(KIND_ADD, 32'h0A00_0000, 32'h0, 32'h1, 5'd1);
      send_word(KIND_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h1, 5'd0);
      send_word(KIND_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h1, 5'd17);
      send_word(KIND_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h1, 5'd31);
      send_word(KIND_ADD, 32'h0, 32'h0, 32'hFFFF_FFFF, 5'd16);
      send_word(KIND_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_0001, 5'd1);
      send_word(KIND_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 5'd2);
      send_word(KIND_ADD, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0002, 5'd3);
      send_word(KIND_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 5'd4);
   endtask

   task automatic test_lookups();
      send_word(KIND_UNICAST, 32'h0A01_0203, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
      send_word(KIND_UNICAST, 32'h0A02_0000, 32'h0, 32'h0, 5'd0);
      send_word(KIND_UNICAST, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd0);
      send_word(KIND_ADD, 32'hE000_0000, 32'hF000_0000, 32'h1111_1111, 5'd5);
      send_word(KIND_ADD, 32'hEFFF_FFFF, 32'hFFFF_FFFF, 32'h2222_2222, 5'd6);
      send_word(KIND_MULTICAST, 32'hEFFF_FFFF, 32'h0, 32'h0, 5'd0);
      send_word(KIND_MULTICAST, 32'hE100_0000, 32'h0, 32'h0, 5'd0);
      send_word(KIND_MULTICAST, 32'h0A00_0000, 32'h0, 32'h0, 5'd0);
      send_word(KIND_UNICAST, 32'hE000_0001, 32'h0, 32'h0, 5'd0);
   endtask

   task automatic test_delete();
      send_word(KIND_DELETE, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 5'd2);
      send_word(KIND_UNICAST, 32'h0A01_0203, 32'h0, 32'h0, 5'd0);
      send_word(KIND_DELETE, 32'h0A01_0000, 32'hFFFF_0000, 32'h0A01_0001, 5'd2);
      send_word(KIND_DELETE, 32'h0, 32'h0, 32'hFFFF_FFFF, 5'd16);
      send_word(KIND_UNICAST, 32'h0B00_0000, 32'h0, 32'h0, 5'd0);
   endtask

   task automatic test_full_table();
      while (routes.size() < ROUTE_SLOTS)
         send_word(KIND_ADD, 32'hE000_0000 | $urandom_range(0, 255), 32'hF000_0000,
            $urandom, 5'($urandom_range(1, 16)));
      send_word(KIND_ADD, 32'h0C00_0000, 32'hFF00_0000, 32'h1, 5'd1);
      send_word(KIND_MULTICAST, 32'hE000_0001, 32'h0, 32'h0, 5'd0);
   endtask

   task automatic test_backpressure();
      route_type r;
      hold_off = 1'b1;
      hold_cycles = 600;
      fork
         repeat (6) send_word(KIND_MULTICAST, 32'hE000_0000 | $urandom_range(0, 255),
            $urandom, $urandom, 5'($urandom));
         begin
            while (hold_cycles > 0) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      drain();
      while (routes.size() > 44) begin
         r = routes[$urandom_range(0, routes.size() - 1)];
         send_word(KIND_DELETE, r.host, r.mask, r.gateway, r.itf);
      end
   endtask

   task automatic test_random();
      route_type r;
      int len;
      logic [31:0] a;
      repeat (20) begin
         burst_mode = ($urandom_range(0, 7) != 0);
         len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32);
         a = $urandom & prefix_mask(len);
         if ($urandom_range(0, 2) == 0) a[31:28] = 4'hE;
         if (len == 0) a = 0;
         case ($urandom_range(0, 9))
            0, 1, 2: send_word(KIND_ADD, a, prefix_mask(len), $urandom,
               5'($urandom_range(1, 16)));
            3: send_word(KIND_ADD, $urandom, $urandom, $urandom, 5'($urandom));
            4: begin
               if (routes.size() > 0) begin
                  r = routes[$urandom_range(0, routes.size() - 1)];
                  send_word(KIND_DELETE, r.host, r.mask, r.gateway, r.itf);
               end else send_word(KIND_DELETE, $urandom, $urandom, $urandom, 5'($urandom));
            end
            5, 6: send_word(KIND_UNICAST, (routes.size() > 0 && $urandom_range(0, 1))
               ? routes[$urandom_range(0, routes.size() - 1)].host ^ ($urandom & 32'hFF)
               : $urandom, $urandom, $urandom, 5'($urandom));
            default: send_word(KIND_MULTICAST, $urandom_range(0, 1)
               ? {4'hE, 28'($urandom)} : $urandom, $urandom, $urandom, 5'($urandom));
         endcase
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_add_checks();
      test_lookups();
      test_delete();
      test_full_table();
      test_backpressure();
      test_random();
      drain();
      repeat (300) @(posedge clock);
      $display("Sent %0d items (adds, deletes, lookups, full table, long stall); checked %0d words.",
         items_sent, words_checked);
      if (errors == 0 && pending_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// File: files.f
src/rlpm_pkg.sv
src/rlpm_if.sv
src/rlpm_ram.sv
src/ipv4_longest_prefix_route_table.sv
tb/ipv4_longest_prefix_route_table_tb.sv
